// ===== rtl/spa_pkg.sv =====
package spa_pkg;

  localparam int KINDS_DEF        = 2;
  localparam int STAGES_DEF       = 8;
  localparam int SHAPE_N_BINS_DEF = 16;
  localparam int SHAPE_K_BINS_DEF = 16;
  localparam int NCNT             = 6;

  localparam logic [2:0] FUNC_STAGE_MARK = 3'd0;
  localparam logic [2:0] FUNC_SHAPE_MARK = 3'd1;
  localparam logic [2:0] FUNC_READ_STAGE = 3'd2;
  localparam logic [2:0] FUNC_READ_SHAPE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR      = 3'd4;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_BADKIND = 2'd1;
  localparam logic [1:0] STATUS_BROKEN  = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  kind;
    logic [3:0]  boundary;
    logic [7:0]  shape_n;
    logic [7:0]  shape_k;
    logic [31:0] cycle_count;
    logic [31:0] retired_count;
    logic [31:0] ifetch_count;
    logic [31:0] ifetch_miss_count;
    logic [31:0] dread_count;
    logic [31:0] dread_miss_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] sample_count;
    logic [31:0] avg_cycles;
    logic [31:0] avg_retired;
    logic [31:0] avg_ifetch;
    logic [31:0] avg_ifetch_miss;
    logic [31:0] avg_dread;
    logic [31:0] avg_dread_miss;
    logic [31:0] bin_count;
  } out_item_t;

endpackage

// ===== rtl/spa_fifo.sv =====
module spa_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  // two-entry queue
  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== rtl/spa_div.sv =====
module spa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  // restoring divider, one quotient bit per cycle
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic [33:0] trial;

  assign trial = {rem, quo[63]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= 33'd0;
      dvs <= divisor;
      cnt <= 7'd0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // saturate: any set bit from 32 up in quotient; a zero divisor gives zero
  assign quotient = (dvs == 32'd0) ? 32'd0 :
                    ((|quo[63:32]) ? 32'hFFFF_FFFF : quo[31:0]);

endmodule

// ===== rtl/spa_back.sv =====
module spa_back #(
  parameter int KINDS        = spa_pkg::KINDS_DEF,
  parameter int STAGES       = spa_pkg::STAGES_DEF,
  parameter int SHAPE_N_BINS = spa_pkg::SHAPE_N_BINS_DEF,
  parameter int SHAPE_K_BINS = spa_pkg::SHAPE_K_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  spa_pkg::in_item_t   q_data,
  output logic                q_pop,
  output logic                res_valid,
  output spa_pkg::out_item_t  res,
  input  logic                res_take,
  output logic                clearing
);

  localparam int SLOTS  = KINDS * STAGES;
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW     = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int NW     = (SHAPE_N_BINS > 1) ? $clog2(SHAPE_N_BINS) : 1;
  localparam int PW     = (SHAPE_K_BINS > 1) ? $clog2(SHAPE_K_BINS) : 1;
  localparam int HDEPTH = KINDS * SHAPE_N_BINS * SHAPE_K_BINS;
  localparam int HW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int CW     = (SLOTS > HDEPTH) ? $clog2(SLOTS + 1) : $clog2(HDEPTH + 1);
  localparam int NC     = spa_pkg::NCNT;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_HRD   = 4'd4;
  localparam logic [3:0] ST_HWR   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_DWAIT = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;
  localparam logic [3:0] ST_HOUT  = 4'd9;

  // stores: per-slot sums and counts in separate arrays, histogram, per-kind state
  logic [63:0] sums [SLOTS][NC];
  logic [31:0] counts [SLOTS];
  logic [31:0] hist [HDEPTH];
  logic [31:0] last [KINDS][NC];
  logic [3:0]  expb [KINDS];
  logic        active [KINDS];

  logic [3:0]  state;
  logic [CW-1:0] clr_idx;
  spa_pkg::in_item_t it;
  spa_pkg::out_item_t ans;
  logic [SW-1:0] slot;
  logic [HW-1:0] haddr;
  logic [63:0] rd_sums [NC];
  logic [31:0] rd_count;
  logic [31:0] hdata;
  logic [2:0]  dsel;
  logic [31:0] avgs [NC];
  logic        dstart;
  logic        dbusy;
  logic        ddone;
  logic [31:0] dq;
  logic [KW-1:0] k;
  logic [NW-1:0] nb;
  logic [PW-1:0] pb;

  assign k  = it.kind[KW-1:0];
  assign nb = (32'(it.shape_n) >= SHAPE_N_BINS) ? NW'(SHAPE_N_BINS - 1) : NW'(it.shape_n);
  assign pb = (32'(it.shape_k) >= SHAPE_K_BINS) ? PW'(SHAPE_K_BINS - 1) : PW'(it.shape_k);

  spa_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(rd_sums[dsel]),
    .divisor(rd_count), .busy(dbusy), .done(ddone), .quotient(dq)
  );

  assign clearing = (state == ST_CLR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign dstart   = (state == ST_DIV);

  always_ff @(posedge clk) begin
    if (state == ST_CLR) begin
      if (clr_idx < CW'(SLOTS)) begin
        counts[SW'(clr_idx)] <= 32'd0;
        for (int c = 0; c < NC; c++) sums[SW'(clr_idx)][c] <= 64'd0;
      end
      if (clr_idx < CW'(HDEPTH)) hist[HW'(clr_idx)] <= 32'd0;
    end else if (state == ST_ACC) begin
      // deltas wrap at 32 bits before they are widened
      counts[slot] <= rd_count + 32'd1;
      sums[slot][0] <= rd_sums[0] + 64'(32'(it.cycle_count - last[k][0]));
      sums[slot][1] <= rd_sums[1] + 64'(32'(it.retired_count - last[k][1]));
      sums[slot][2] <= rd_sums[2] + 64'(32'(it.ifetch_count - last[k][2]));
      sums[slot][3] <= rd_sums[3] + 64'(32'(it.ifetch_miss_count - last[k][3]));
      sums[slot][4] <= rd_sums[4] + 64'(32'(it.dread_count - last[k][4]));
      sums[slot][5] <= rd_sums[5] + 64'(32'(it.dread_miss_count - last[k][5]));
    end else if (state == ST_HWR) begin
      hist[haddr] <= hdata + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_count <= counts[slot];
    hdata    <= hist[haddr];
    for (int c = 0; c < NC; c++) rd_sums[c] <= sums[slot][c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_idx   <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < KINDS; i++) begin
        expb[i]   <= 4'd0;
        active[i] <= 1'b0;
      end
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == CW'((SLOTS > HDEPTH) ? SLOTS - 1 : HDEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            it    <= q_data;
            ans   <= '0;
            slot  <= SW'(32'(q_data.kind) * STAGES +
                     ((q_data.func == spa_pkg::FUNC_STAGE_MARK) ?
                      32'(q_data.boundary) - 1 : 32'(q_data.boundary)));
            haddr <= HW'((32'(q_data.kind) * SHAPE_N_BINS +
                     ((32'(q_data.shape_n) >= SHAPE_N_BINS) ? SHAPE_N_BINS - 1 :
                      32'(q_data.shape_n))) * SHAPE_K_BINS +
                     ((32'(q_data.shape_k) >= SHAPE_K_BINS) ? SHAPE_K_BINS - 1 :
                      32'(q_data.shape_k)));
            state <= ST_RD;
          end
        end
        ST_RD: begin
          // address settled, read data lands next cycle; classify now
          if (it.func == spa_pkg::FUNC_CLEAR) begin
            for (int i = 0; i < KINDS; i++) begin
              expb[i]   <= 4'd0;
              active[i] <= 1'b0;
            end
            clr_idx <= '0;
            state   <= ST_OUT;
          end else if (it.func > spa_pkg::FUNC_CLEAR) begin
            state <= ST_OUT;
          end else if (32'(it.kind) >= KINDS) begin
            ans.status <= spa_pkg::STATUS_BADKIND;
            state      <= ST_OUT;
          end else begin
            unique case (it.func)
              spa_pkg::FUNC_STAGE_MARK: begin
                if (it.boundary == 4'd0) begin
                  last[k][0] <= it.cycle_count;
                  last[k][1] <= it.retired_count;
                  last[k][2] <= it.ifetch_count;
                  last[k][3] <= it.ifetch_miss_count;
                  last[k][4] <= it.dread_count;
                  last[k][5] <= it.dread_miss_count;
                  expb[k]    <= 4'd1;
                  active[k]  <= 1'b1;
                  state      <= ST_OUT;
                end else if (!active[k] || it.boundary != expb[k] ||
                             32'(it.boundary) > STAGES) begin
                  active[k]  <= 1'b0;
                  ans.status <= spa_pkg::STATUS_BROKEN;
                  state      <= ST_OUT;
                end else begin
                  state <= ST_ACC;
                end
              end
              spa_pkg::FUNC_SHAPE_MARK: state <= ST_HRD;
              spa_pkg::FUNC_READ_STAGE: begin
                if (32'(it.boundary) < STAGES) begin
                  dsel  <= 3'd0;
                  state <= ST_DIV;
                end else begin
                  state <= ST_OUT;
                end
              end
              default: state <= ST_HRD;
            endcase
          end
        end
        ST_ACC: begin
          last[k][0] <= it.cycle_count;
          last[k][1] <= it.retired_count;
          last[k][2] <= it.ifetch_count;
          last[k][3] <= it.ifetch_miss_count;
          last[k][4] <= it.dread_count;
          last[k][5] <= it.dread_miss_count;
          expb[k]    <= expb[k] + 4'd1;
          if (32'(it.boundary) == STAGES) active[k] <= 1'b0;
          state <= ST_OUT;
        end
        ST_HRD: begin
          state <= (it.func == spa_pkg::FUNC_SHAPE_MARK) ? ST_HWR : ST_HOUT;
        end
        ST_HWR: state <= ST_OUT;
        ST_HOUT: begin
          ans.bin_count <= hdata;
          state         <= ST_OUT;
        end
        ST_DIV: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (ddone) begin
            avgs[dsel] <= dq;
            if (dsel == 3'(NC - 1)) begin
              ans.sample_count    <= rd_count;
              ans.avg_cycles      <= avgs[0];
              ans.avg_retired     <= avgs[1];
              ans.avg_ifetch      <= avgs[2];
              ans.avg_ifetch_miss <= avgs[3];
              ans.avg_dread       <= avgs[4];
              ans.avg_dread_miss  <= dq;
              state               <= ST_OUT;
            end else begin
              dsel  <= dsel + 3'd1;
              state <= ST_DIV;
            end
          end
        end
        ST_OUT: begin
          // hold the finished result until the output register is free
          if (!res_valid || res_take) begin
            res       <= ans;
            res_valid <= 1'b1;
            state     <= (it.func == spa_pkg::FUNC_CLEAR) ? ST_CLR : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic unused_bits;
  assign unused_bits = dbusy ^ (|nb) ^ (|pb);

endmodule

// ===== rtl/stage_profile_accumulator.sv =====
// Stage profile accumulator.
// Input channel: drive in_item and raise push; a beat is taken on a clock
// edge with push high and full low. Items land in a two-entry queue, so a
// burst of two is taken at full rate.
// Result channel: exactly one result beat per input item, in order. While
// empty is low the oldest result sits on out_item; pop takes it.
// Path from the accepting edge to the result: a run start, a broken run,
// a bad kind, a clear, an out-of-range read or an unused code go straight
// to the result, an accumulating stage mark adds a step, shape items read
// a bin and write or report it, and a stage read runs the shared 64-by-32
// one-bit-a-cycle divider once per counter. One item is executed at a time.
// Reset (rst, synchronous) starts a clearing pass over the histogram and
// the stage sums, one entry a cycle. A clear item starts the same pass
// after its result is handed off. Items are queued during the pass but
// not executed.
// When the receiver stalls, one result waits in the output register and
// the back end holds the next one; the input queue then fills and full
// rises.
module stage_profile_accumulator #(
  parameter int KINDS        = spa_pkg::KINDS_DEF,
  parameter int STAGES       = spa_pkg::STAGES_DEF,
  parameter int SHAPE_N_BINS = spa_pkg::SHAPE_N_BINS_DEF,
  parameter int SHAPE_K_BINS = spa_pkg::SHAPE_K_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  spa_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output spa_pkg::out_item_t out_item
);

  logic              q_empty;
  logic              q_pop;
  spa_pkg::in_item_t q_data;
  logic              res_valid;
  logic              clearing;

  // front: hold accepted beats until the back end is free
  spa_fifo #(.WIDTH($bits(spa_pkg::in_item_t))) u_front (
    .clk(clk), .rst(rst), .wr(push), .wdata(in_item), .full(full),
    .rd(q_pop), .rdata(q_data), .empty(q_empty)
  );

  // back: execute one item, drive the result register
  spa_back #(
    .KINDS(KINDS), .STAGES(STAGES),
    .SHAPE_N_BINS(SHAPE_N_BINS), .SHAPE_K_BINS(SHAPE_K_BINS)
  ) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .res_valid(res_valid), .res(out_item), .res_take(pop), .clearing(clearing)
  );

  assign empty = !res_valid;

  // no item leaves the queue while the clearing pass runs
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop) else $error("item taken during clear");

  // a waiting result that is not taken stays put
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed");

  // status only takes defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.status <= spa_pkg::STATUS_BROKEN) else $error("bad status");

endmodule
